// ===== design/firdb_pkg.sv =====
`default_nettype none

package firdb_pkg;

    localparam int QUARTER_LEN = 1025;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    localparam int POINT_BITS = 10;
    localparam int DVD_W = POINT_BITS + 32;
    localparam int POWER_Q = 40;
    localparam int LOG_ITERS = 16;
    localparam logic signed [47:0] DB_PER_LOG2_Q16 = 48'sd197283;
    localparam logic signed [47:0] DB_MIN = -48'sd25600;
    localparam logic signed [47:0] DB_MAX = 48'sd12800;

    localparam logic [1:0] CFG_NUM_TAPS = 2'd0;
    localparam logic [1:0] CFG_NUM_POINTS = 2'd1;
    localparam logic [1:0] CFG_COMPLEX = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef logic [15:0] sine_tab_t [0:QUARTER_LEN-1];

    function automatic sine_tab_t build_sine();
        sine_tab_t tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int p = 0; p < QUARTER_LEN; p++)
        begin
            x = ((64'(p) << 20) * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            t = ONE_Q30;
            t = ONE_Q30 - (((x2 * t) >> 30) / 110);
            t = ONE_Q30 - (((x2 * t) >> 30) / 72);
            t = ONE_Q30 - (((x2 * t) >> 30) / 42);
            t = ONE_Q30 - (((x2 * t) >> 30) / 20);
            t = ONE_Q30 - (((x2 * t) >> 30) / 6);
            s = (x * t) >> 30;
            s = (s + 64'd16384) >> 15;
            if (s > 64'd32768)
            begin
                s = 64'd32768;
            end
            tab[p] = s[15:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_Q = build_sine();

    // full-turn sine from the quarter wave, 4096 steps per turn
    function automatic logic signed [16:0] table_sine(input logic [11:0] addr);
        logic [10:0] idx;
        logic signed [16:0] v;
        idx = addr[10] ? 11'(11'd1024 - {1'b0, addr[9:0]}) : {1'b0, addr[9:0]};
        v = signed'({1'b0, SINE_Q[idx]});
        return addr[11] ? -v : v;
    endfunction

endpackage

`default_nettype wire

// ===== design/fir_frequency_response_db.sv =====
`default_nettype none

// FIR frequency response in dB. Load transfers write one tap into the tap RAM; evaluate
// transfers return 20*log10 of the response magnitude at one frequency point in Q8.8,
// floored at -100 dB and capped at +50 dB. An evaluate passes through the 42-step
// phase-increment divider, then one tap per cycle through the tap RAM and the product and
// accumulate registers of the multiply-accumulate pipeline, then rounding, squaring and
// summing, a bit-serial normalize, sixteen squaring steps for the logarithm, the dB
// scaling and the output register. A zero response skips the logarithm and the dB scaling.
// One item is worked on at a time; a finished result waits in the output register while
// the next item is taken.

module fir_frequency_response_db
    import firdb_pkg::*;
#(
    parameter int MAX_TAPS = 128,
    parameter int MAX_POINTS = 1024,
    parameter int TAP_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [10:0]                cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       action,
    input  wire logic [6:0]                 tap_index,
    input  wire logic signed [TAP_BITS-1:0] tap_re,
    input  wire logic signed [TAP_BITS-1:0] tap_im,
    input  wire logic [POINT_BITS-1:0]      point_index,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [POINT_BITS-1:0]           result_point,
    output logic signed [15:0]              magnitude_db
);

    localparam int ADDR_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int PTS_W = $clog2(MAX_POINTS + 1);
    localparam int PROD_W = TAP_BITS + 17;
    localparam int ACC_W = PROD_W + ADDR_W + 2;
    localparam int MAG_SHIFT = TAP_BITS - 6;
    localparam int MAG_W = ACC_W - MAG_SHIFT + 1;
    localparam int PW_W = 2 * MAG_W + 1;
    localparam int MSB_W = $clog2(PW_W);
    localparam int IDX_W = (ADDR_W > 7) ? ADDR_W : 7;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV = 4'd1;
    localparam logic [3:0] S_MAC = 4'd2;
    localparam logic [3:0] S_MAG = 4'd3;
    localparam logic [3:0] S_SQR = 4'd4;
    localparam logic [3:0] S_SUM = 4'd5;
    localparam logic [3:0] S_NORM = 4'd6;
    localparam logic [3:0] S_LOG = 4'd7;
    localparam logic [3:0] S_DBM = 4'd8;
    localparam logic [3:0] S_DBQ = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [7:0] num_taps_reg;
    logic [10:0] num_points_reg;
    logic complex_reg;

    logic [POINT_BITS-1:0] point_reg, point_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [PTS_W-1:0] pts_reg, pts_next;
    logic cplx_reg, cplx_next;

    logic [PTS_W:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0] div_cnt_reg, div_cnt_next;

    logic [CNT_W-1:0] k_reg, k_next;
    logic [31:0] phase_reg, phase_next;
    logic v1_reg, v1_next;
    logic pv_reg, pv_next;
    logic signed [16:0] s_reg, s_next;
    logic signed [16:0] c_reg, c_next;
    logic signed [PROD_W-1:0] p_rc_reg, p_rs_reg, p_ic_reg, p_is_reg;
    logic signed [PROD_W-1:0] p_rc_next, p_rs_next, p_ic_next, p_is_next;
    logic signed [ACC_W-1:0] acc_re_reg, acc_re_next;
    logic signed [ACC_W-1:0] acc_im_reg, acc_im_next;

    logic [MAG_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [2*MAG_W-1:0] asq_reg, asq_next, bsq_reg, bsq_next;
    logic [PW_W-1:0] pw_reg, pw_next;
    logic [MSB_W-1:0] msb_reg, msb_next;
    logic [30:0] m_reg, m_next;
    logic [15:0] frac_reg, frac_next;
    logic [3:0] iter_reg, iter_next;
    logic signed [47:0] v_reg, v_next;
    logic signed [15:0] db_reg, db_next;

    logic out_valid_reg, out_valid_next;
    logic [POINT_BITS-1:0] out_point_reg, out_point_next;
    logic signed [15:0] out_db_reg, out_db_next;

    logic in_xfer;
    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [2*TAP_BITS-1:0] ram_wdata;
    logic [2*TAP_BITS-1:0] ram_rdata;
    logic [ADDR_W-1:0] ram_raddr;

    logic [PTS_W+1:0] rem_sh;
    logic [12:0] addr_round;
    logic [11:0] sin_addr;
    logic signed [TAP_BITS-1:0] tr, ti;
    logic [ACC_W-1:0] abs_re, abs_im;
    logic [ACC_W:0] rnd_re, rnd_im;
    logic [61:0] m_sq;
    logic [31:0] m_sh;
    logic signed [31:0] lg;
    logic signed [47:0] qv;

    firdb_ram #(
        .WIDTH(2 * TAP_BITS),
        .DEPTH(MAX_TAPS)
    ) u_tap_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign result_point = out_point_reg;
    assign magnitude_db = out_db_reg;

    assign ram_we = in_xfer && (action == ACT_LOAD) && (32'(tap_index) < MAX_TAPS);
    assign ram_waddr = ADDR_W'(IDX_W'(tap_index));
    assign ram_wdata = {tap_im, tap_re};
    assign ram_raddr = k_reg[ADDR_W-1:0];

    assign tr = signed'(ram_rdata[TAP_BITS-1:0]);
    assign ti = cplx_reg ? signed'(ram_rdata[2*TAP_BITS-1:TAP_BITS]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg <= 8'd33;
            num_points_reg <= 11'd512;
            complex_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUM_TAPS: num_taps_reg <= cfg_data[7:0];
                CFG_NUM_POINTS: num_points_reg <= cfg_data;
                CFG_COMPLEX: complex_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        point_next = point_reg;
        n_next = n_reg;
        pts_next = pts_reg;
        cplx_next = cplx_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        div_cnt_next = div_cnt_reg;
        k_next = k_reg;
        phase_next = phase_reg;
        v1_next = 1'b0;
        pv_next = 1'b0;
        s_next = s_reg;
        c_next = c_reg;
        p_rc_next = p_rc_reg;
        p_rs_next = p_rs_reg;
        p_ic_next = p_ic_reg;
        p_is_next = p_is_reg;
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        a_next = a_reg;
        b_next = b_reg;
        asq_next = asq_reg;
        bsq_next = bsq_reg;
        pw_next = pw_reg;
        msb_next = msb_reg;
        m_next = m_reg;
        frac_next = frac_reg;
        iter_next = iter_reg;
        v_next = v_reg;
        db_next = db_reg;
        out_point_next = out_point_reg;
        out_db_next = out_db_reg;
        out_valid_next = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;

        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        addr_round = 13'(phase_reg[31:19]) + 13'd1;
        sin_addr = addr_round[12:1];
        abs_re = acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
        abs_im = acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);
        rnd_re = (ACC_W + 1)'(abs_re) + ((ACC_W + 1)'(1) << (MAG_SHIFT - 1));
        rnd_im = (ACC_W + 1)'(abs_im) + ((ACC_W + 1)'(1) << (MAG_SHIFT - 1));
        m_sq = 62'(m_reg) * 62'(m_reg);
        m_sh = m_sq[61:30];
        lg = ((32'(msb_reg) - 32'sd40) <<< 16) + signed'(32'(frac_reg));
        qv = (v_reg + 48'sd8388608) >>> 24;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (action == ACT_EVAL))
                begin
                    point_next = point_index;
                    cplx_next = complex_reg;
                    n_next = (32'(num_taps_reg) > MAX_TAPS) ? CNT_W'(MAX_TAPS)
                                                            : CNT_W'(num_taps_reg);
                    if (num_points_reg == 11'd0)
                    begin
                        pts_next = PTS_W'(1);
                    end
                    else if (32'(num_points_reg) > MAX_POINTS)
                    begin
                        pts_next = PTS_W'(MAX_POINTS);
                    end
                    else
                    begin
                        pts_next = PTS_W'(num_points_reg);
                    end
                    dvd_next = complex_reg ? {point_index, 32'd0}
                                           : {1'b0, point_index, 31'd0};
                    rem_next = '0;
                    div_cnt_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (rem_sh >= (PTS_W + 2)'(pts_reg))
                begin
                    rem_next = (PTS_W + 1)'(rem_sh - (PTS_W + 2)'(pts_reg));
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[PTS_W:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(DVD_W - 1))
                begin
                    k_next = '0;
                    phase_next = '0;
                    acc_re_next = '0;
                    acc_im_next = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (k_reg < n_reg)
                begin
                    s_next = table_sine(sin_addr);
                    c_next = table_sine(12'(sin_addr + 12'd1024));
                    phase_next = phase_reg + quo_reg;
                    k_next = k_reg + CNT_W'(1);
                    v1_next = 1'b1;
                end
                // ram data and sine/cosine line up in the cycle after the read
                if (v1_reg)
                begin
                    p_rc_next = PROD_W'(tr) * PROD_W'(c_reg);
                    p_rs_next = PROD_W'(tr) * PROD_W'(s_reg);
                    p_ic_next = PROD_W'(ti) * PROD_W'(c_reg);
                    p_is_next = PROD_W'(ti) * PROD_W'(s_reg);
                    pv_next = 1'b1;
                end
                if (pv_reg)
                begin
                    acc_re_next = acc_re_reg + ACC_W'(p_rc_reg) - ACC_W'(p_is_reg);
                    acc_im_next = acc_im_reg + ACC_W'(p_rs_reg) + ACC_W'(p_ic_reg);
                end
                if ((k_reg == n_reg) && !v1_reg && !pv_reg)
                begin
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                a_next = MAG_W'(rnd_re >> MAG_SHIFT);
                b_next = MAG_W'(rnd_im >> MAG_SHIFT);
                state_next = S_SQR;
            end
            S_SQR:
            begin
                asq_next = (2 * MAG_W)'(a_reg) * (2 * MAG_W)'(a_reg);
                bsq_next = (2 * MAG_W)'(b_reg) * (2 * MAG_W)'(b_reg);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                pw_next = PW_W'(asq_reg) + PW_W'(bsq_reg);
                msb_next = MSB_W'(PW_W - 1);
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (pw_reg == '0)
                begin
                    db_next = 16'(DB_MIN);
                    state_next = S_OUT;
                end
                else if (pw_reg[PW_W-1])
                begin
                    m_next = pw_reg[PW_W-1 -: 31];
                    frac_next = '0;
                    iter_next = '0;
                    state_next = S_LOG;
                end
                else
                begin
                    pw_next = {pw_reg[PW_W-2:0], 1'b0};
                    msb_next = msb_reg - MSB_W'(1);
                end
            end
            S_LOG:
            begin
                // one fraction bit of log2 per squaring
                if (m_sh[31])
                begin
                    m_next = m_sh[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next = m_sh[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'(LOG_ITERS - 1))
                begin
                    state_next = S_DBM;
                end
            end
            S_DBM:
            begin
                v_next = 48'(lg) * DB_PER_LOG2_Q16;
                state_next = S_DBQ;
            end
            S_DBQ:
            begin
                if (qv < DB_MIN)
                begin
                    db_next = 16'(DB_MIN);
                end
                else if (qv > DB_MAX)
                begin
                    db_next = 16'(DB_MAX);
                end
                else
                begin
                    db_next = 16'(qv);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_point_next = point_reg;
                    out_db_next = db_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            v1_reg <= 1'b0;
            pv_reg <= 1'b0;
            k_reg <= '0;
            div_cnt_reg <= '0;
            iter_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            v1_reg <= v1_next;
            pv_reg <= pv_next;
            k_reg <= k_next;
            div_cnt_reg <= div_cnt_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
        n_reg <= n_next;
        pts_reg <= pts_next;
        cplx_reg <= cplx_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        phase_reg <= phase_next;
        s_reg <= s_next;
        c_reg <= c_next;
        p_rc_reg <= p_rc_next;
        p_rs_reg <= p_rs_next;
        p_ic_reg <= p_ic_next;
        p_is_reg <= p_is_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        a_reg <= a_next;
        b_reg <= b_next;
        asq_reg <= asq_next;
        bsq_reg <= bsq_next;
        pw_reg <= pw_next;
        msb_reg <= msb_next;
        m_reg <= m_next;
        frac_reg <= frac_next;
        v_reg <= v_next;
        db_reg <= db_next;
        out_point_reg <= out_point_next;
        out_db_reg <= out_db_next;
    end

    // tap counter never passes the tap count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (k_reg <= n_reg))
        else $error("tap counter past tap count");

    // the log stage always starts from a normalized mantissa
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOG) |-> m_reg[30])
        else $error("mantissa not normalized");

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_db_reg)))
        else $error("pending result lost");

    // pipeline valids only run during the multiply-accumulate
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || pv_reg) |-> (state_reg == S_MAC))
        else $error("tap pipeline active outside accumulate");

endmodule

`default_nettype wire

// ===== design/firdb_ram.sv =====
`default_nettype none

module firdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sim/fir_frequency_response_db_tb.sv =====
`timescale 1ns / 1ps

module fir_frequency_response_db_tb
    import firdb_pkg::*;
;

    typedef struct {
        logic [9:0]         point;
        logic signed [15:0] db;
    } response_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = CFG_NUM_TAPS;
    logic [10:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               action = ACT_LOAD;
    logic [6:0]         tap_index = '0;
    logic signed [15:0] tap_re = '0;
    logic signed [15:0] tap_im = '0;
    logic [9:0]         point_index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [9:0]         result_point;
    logic signed [15:0] magnitude_db;

    response_t          pending_db[$];
    int                 errors = 0;
    bit                 quiet = 1'b0;
    int                 quarter_wave[0:1024];
    logic signed [15:0] coef_re[0:127];
    logic signed [15:0] coef_im[0:127];
    int                 taps_setting = 33;
    int                 points_setting = 512;
    bit                 complex_setting = 1'b0;

    fir_frequency_response_db dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .tap_index(tap_index), .tap_re(tap_re), .tap_im(tap_im),
        .point_index(point_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_point(result_point), .magnitude_db(magnitude_db)
    );

    always #2 clk = ~clk;

    // odd taylor series of sin over a quarter turn, q30 truncated, rounded to q15
    function automatic int quarter_sin(int p);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x = ((64'(p) << 20) * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        t = (64'd1 << 30) - (((x2 * t) >> 30) / 110);
        t = (64'd1 << 30) - (((x2 * t) >> 30) / 72);
        t = (64'd1 << 30) - (((x2 * t) >> 30) / 42);
        t = (64'd1 << 30) - (((x2 * t) >> 30) / 20);
        t = (64'd1 << 30) - (((x2 * t) >> 30) / 6);
        s = (((x * t) >> 30) + 64'd16384) >> 15;
        if (s > 64'd32768)
        begin
            s = 64'd32768;
        end
        return int'(s);
    endfunction

    function automatic longint wave(logic [11:0] a);
        int v;
        v = a[10] ? quarter_wave[1024 - int'(a[9:0])] : quarter_wave[a[9:0]];
        return a[11] ? -longint'(v) : longint'(v);
    endfunction

    function automatic logic signed [15:0] power_db(logic [63:0] pw);
        int     msb;
        int     frac;
        logic [63:0] m;
        longint lg;
        longint q;
        if (pw == 0)
        begin
            return -16'sd25600;
        end
        msb = 63;
        while (!pw[msb])
        begin
            msb--;
        end
        m = (msb >= 30) ? (pw >> (msb - 30)) : (pw << (30 - msb));
        frac = 0;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        lg = (longint'(msb) - 40) * 65536 + longint'(frac);
        q = (lg * 197283 + (64'sd1 <<< 23)) >>> 24;
        if (q < -25600)
        begin
            q = -25600;
        end
        if (q > 12800)
        begin
            q = 12800;
        end
        return 16'(q);
    endfunction

    function automatic logic signed [15:0] response_db(logic [9:0] pt);
        int          n;
        int          pts;
        logic [31:0] step;
        logic [31:0] phase;
        logic [11:0] addr;
        longint      s;
        longint      c;
        longint      tr;
        longint      ti;
        longint      acc_re;
        longint      acc_im;
        logic [63:0] a;
        logic [63:0] b;
        n = (taps_setting > 128) ? 128 : taps_setting;
        pts = (points_setting == 0) ? 1 : ((points_setting > 1024) ? 1024 : points_setting);
        step = 32'((64'(pt) << (complex_setting ? 32 : 31)) / 64'(pts));
        phase = '0;
        acc_re = 0;
        acc_im = 0;
        for (int k = 0; k < n; k++)
        begin
            addr = 12'(((phase >> 19) + 32'd1) >> 1);
            s = wave(addr);
            c = wave(addr + 12'd1024);
            tr = coef_re[k];
            ti = complex_setting ? longint'(coef_im[k]) : 0;
            acc_re += tr * c - ti * s;
            acc_im += tr * s + ti * c;
            phase += step;
        end
        a = ((acc_re < 0 ? -acc_re : acc_re) + 512) >> 10;
        b = ((acc_im < 0 ? -acc_im : acc_im) + 512) >> 10;
        return power_db(a * a + b * b);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // caller stands at a rising edge, and is left at the edge of the transfer
    task automatic send_item(logic act, logic [6:0] idx, logic signed [15:0] re,
                             logic signed [15:0] im, logic [9:0] pt);
        int        gap;
        response_t r;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        tap_index <= idx;
        tap_re <= re;
        tap_im <= im;
        point_index <= pt;
        do
        begin
            @(negedge clk);
        end
        while (in_stall);
        @(posedge clk);
        if (act == ACT_LOAD)
        begin
            coef_re[idx] = re;
            coef_im[idx] = im;
        end
        else
        begin
            r.point = pt;
            r.db = response_db(pt);
            pending_db.push_back(r);
        end
    endtask

    task automatic load_tap(logic [6:0] idx, logic signed [15:0] re, logic signed [15:0] im);
        send_item(ACT_LOAD, idx, re, im, 10'($urandom));
    endtask

    task automatic eval_point(logic [9:0] pt);
        send_item(ACT_EVAL, 7'($urandom), 16'($urandom), 16'($urandom), pt);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_db.size() != 0)
        begin
            @(posedge clk);
        end
        // a trailing load may still be in flight
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 11'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_NUM_TAPS: taps_setting = value & 8'hFF;
            CFG_NUM_POINTS: points_setting = value & 11'h7FF;
            CFG_COMPLEX: complex_setting = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(int taps, int points, bit cplx);
        drain();
        write_reg(CFG_NUM_TAPS, taps);
        write_reg(CFG_NUM_POINTS, points);
        write_reg(CFG_COMPLEX, int'(cplx));
    endtask

    function automatic logic signed [15:0] rand_tap();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_fill_taps;
        for (int k = 0; k < 128; k++)
        begin
            load_tap(7'(k), rand_tap(), rand_tap());
        end
    endtask

    task automatic test_directed;
        eval_point(10'd0);
        eval_point(10'd1023);
        eval_point(10'd256);
        set_config(128, 1024, 1'b1);
        eval_point(10'd0);
        eval_point(10'd1023);
        eval_point(10'd511);
        // all taps summed at full scale
        set_config(255, 2047, 1'b0);
        eval_point(10'd1);
        eval_point(10'd1000);
        // no taps gives the floor
        set_config(0, 0, 1'b1);
        eval_point(10'd0);
        eval_point(10'd700);
        // single point, every index wraps
        set_config(1, 1, 1'b0);
        eval_point(10'd0);
        eval_point(10'd5);
        // zero response, then extreme taps
        set_config(4, 8, 1'b1);
        for (int k = 0; k < 4; k++)
        begin
            load_tap(7'(k), 16'sh0000, 16'sh0000);
        end
        eval_point(10'd0);
        eval_point(10'd3);
        load_tap(7'd0, 16'sh8000, 16'sh8000);
        load_tap(7'd1, 16'sh7FFF, 16'sh7FFF);
        eval_point(10'd0);
        eval_point(10'd4);
        eval_point(10'd9);
    endtask

    task automatic test_random;
        int taps;
        int points;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: taps = 128;
                1: taps = 255;
                2: taps = 1;
                3: taps = 0;
                default: taps = $urandom_range(1, 40);
            endcase
            case (ph % 5)
                0: points = 1024;
                1: points = 2047;
                2: points = 0;
                3: points = 1;
                default: points = $urandom_range(2, 1024);
            endcase
            set_config(taps, points, ph[0] ^ 1'($urandom_range(0, 1)));
            quiet = (ph % 4 == 3);
            for (int i = 0; i < 60; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    load_tap(7'($urandom), rand_tap(), rand_tap());
                end
                else if ($urandom_range(0, 7) == 0 || points == 0)
                begin
                    eval_point(10'($urandom));
                end
                else
                begin
                    eval_point(10'($urandom_range(0, (points > 1024 ? 1024 : points) - 1)));
                end
            end
        end
        quiet = 1'b0;
    endtask

    // result side: random stall per result, compare against the oldest expectation
    initial
    begin
        int        n;
        response_t want;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 18);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
            begin
                @(negedge clk);
            end
            while (!out_valid);
            if (pending_db.size() == 0)
            begin
                report_mismatch("unexpected transfer, point", result_point, -1);
            end
            else
            begin
                want = pending_db.pop_front();
                if (result_point !== want.point)
                begin
                    report_mismatch("result_point", result_point, want.point);
                end
                if (magnitude_db !== want.db)
                begin
                    report_mismatch("magnitude_db", magnitude_db, want.db);
                end
            end
            @(posedge clk);
        end
    end

    initial
    begin
        for (int p = 0; p <= 1024; p++)
        begin
            quarter_wave[p] = quarter_sin(p);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_taps();
        test_directed();
        test_random();
        drain();
        if (errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
